// ===== rtl/accel_mag_to_quaternion_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the orientation quaternion core
// Clocked property checks, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef ACCEL_MAG_TO_QUATERNION_CORE_MACROS_SVH
`define ACCEL_MAG_TO_QUATERNION_CORE_MACROS_SVH

// Check on every rising edge outside reset.
`define AMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define AMQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/amq_pkg.sv =====
// ----------------------------------------------------------------------------
// amq_pkg
// Widths, types and helper functions for the orientation quaternion core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int IN_DATA_W  = 6 * IN_W;
  localparam int OUT_DATA_W = 4 * OUT_W;

  // cross product and vector normalization
  localparam int PROD_W   = 2 * IN_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int MAG_W    = PROD_W;
  localparam int POS_W    = $clog2(MAG_W);
  localparam int NRM_W    = 30;
  localparam int NRM_TOP  = NRM_W - 1;
  localparam int SQ_W     = 2 * NRM_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int LEN_W    = SUM_W / 2;
  localparam int L1_STEPS = LEN_W;
  localparam int Q1_W     = FRAC_BITS + 1;
  localparam int DNUM1_W  = NRM_W + FRAC_BITS + 1;
  localparam int D1_STEPS = Q1_W;

  // north vector and matrix
  localparam int UV_W = FRAC_BITS + 2;
  localparam int NP_W = 2 * UV_W;
  localparam int ND_W = NP_W + 1;
  localparam int M_W  = FRAC_BITS + 4;
  localparam int TR_W = M_W + 2;
  localparam int T_W  = M_W;

  // root and quotients of the quaternion step
  localparam int R2_W     = (T_W + FRAC_BITS) / 2;
  localparam int RA_W     = 2 * R2_W;
  localparam int L2_STEPS = R2_W;
  localparam int S_W      = R2_W + 1;
  localparam int NUM_W    = M_W + 1;
  localparam int DNUM2_W  = NUM_W + FRAC_BITS + 1;
  localparam int Q2_W     = DNUM2_W - (FRAC_BITS / 2 + 1);
  localparam int D2_STEPS = Q2_W;
  localparam int DV2_W    = S_W + Q2_W;

  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } branch_t;

  typedef struct packed {
    logic [2:0][NRM_W-1:0] m;
    logic [2:0]            neg;
  } nvec_t;

  typedef struct packed {
    branch_t             br;
    logic [8:0][M_W-1:0] m;
  } mat_t;

  typedef struct packed {
    branch_t         br;
    logic [R2_W-1:0] own;
    logic [3:0]      neg;
    logic [S_W-1:0]  den;
  } d2c_t;

  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [CROSS_W-1:0] v);
    logic signed [CROSS_W-1:0] n;
    n = -v;
    return v[CROSS_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

  function automatic logic [POS_W-1:0] lead_pos(input logic [MAG_W-1:0] x);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (x[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  // round(v / 2^FRAC_BITS), half away from zero
  function automatic logic [M_W-1:0] round_frac(input logic signed [ND_W-1:0] v);
    logic [ND_W-1:0] mg;
    logic [ND_W-1:0] q;
    mg = v[ND_W-1] ? ND_W'(-v) : ND_W'(v);
    q  = (mg + (ND_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[ND_W-1] ? M_W'(-q) : M_W'(q);
  endfunction

endpackage

// ===== rtl/accel_mag_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// accel_mag_to_quaternion_core
// Accepts one item per cycle except while the pipe holds.
// Depth is set by the two bit-per-stage square roots (31 and 16 stages) and
// the two bit-per-stage dividers (15 and 26 stages) in series.
// The whole pipe holds when the output register is full and not taken.
// Reset (rst_n low, synchronous) clears all valid bits; data regs keep junk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "accel_mag_to_quaternion_core_macros.svh"

module accel_mag_to_quaternion_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z (16 bits each, lowest first)
  input  logic [amq_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // q_scalar, q_i, q_j, q_k (16 bits each, lowest first)
  output logic [amq_pkg::OUT_DATA_W-1:0] out_tdata,
  // degenerate
  output logic                           out_tuser
);
  import amq_pkg::*;

  localparam int ST_MAX = 5;
  localparam int NST    = 8 + L1_STEPS + 1 + D1_STEPS + 5 + L2_STEPS + 1 + D2_STEPS + 1;

  // --------------------------------------------------------------------------
  // Pipeline control: one enable for all stages, valid bits shift with data
  // --------------------------------------------------------------------------
  logic           adv;
  logic [NST:1]   vld_r;
  logic [NST-1:ST_MAX] deg_r;
  logic           deg_nxt;

  assign adv       = !vld_r[NST] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-1:1], in_tvalid};
    end
  end

  // degenerate flag rides along from the max stage on
  always_ff @(posedge clk) begin
    if (adv) begin
      deg_r[ST_MAX]          <= deg_nxt;
      deg_r[NST-1:ST_MAX+1]  <= deg_r[NST-2:ST_MAX];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture item. Stage 2: cross products. Stage 3: east raw vector
  // --------------------------------------------------------------------------
  logic signed [IN_W-1:0]    acc_r  [3];
  logic signed [IN_W-1:0]    mgf_r  [3];
  logic signed [IN_W-1:0]    acc2_r [3];
  logic signed [IN_W-1:0]    acc3_r [3];
  logic signed [PROD_W-1:0]  pr_r   [6];
  logic signed [CROSS_W-1:0] cr_r   [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i]  <= in_tdata[i*IN_W +: IN_W];
        mgf_r[i]  <= in_tdata[(i+3)*IN_W +: IN_W];
        acc2_r[i] <= acc_r[i];
        acc3_r[i] <= acc2_r[i];
      end
      pr_r[0] <= acc_r[1] * mgf_r[2];
      pr_r[1] <= acc_r[2] * mgf_r[1];
      pr_r[2] <= acc_r[2] * mgf_r[0];
      pr_r[3] <= acc_r[0] * mgf_r[2];
      pr_r[4] <= acc_r[0] * mgf_r[1];
      pr_r[5] <= acc_r[1] * mgf_r[0];
      for (int i = 0; i < 3; i++) begin
        cr_r[i] <= CROSS_W'(pr_r[2*i]) - CROSS_W'(pr_r[2*i+1]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitudes and signs (lane 0 accel, lane 1 east)
  // Stage 5: largest component and zero test
  // Stage 6: shift so the largest component lands in [2^29, 2^30)
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0] ab_r  [2][3];
  logic [2:0]       ng_r  [2];
  logic [MAG_W-1:0] ab5_r [2][3];
  logic [2:0]       ng5_r [2];
  logic [MAG_W-1:0] mx5_r [2];
  logic [MAG_W-1:0] mx_nxt [2];
  nvec_t            nv_nxt [2];
  nvec_t            nv6_r  [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ab_r[0][i]    <= abs_mag(CROSS_W'(acc3_r[i]));
        ng_r[0][i]    <= acc3_r[i][IN_W-1];
        ab_r[1][i]    <= abs_mag(cr_r[i]);
        ng_r[1][i]    <= cr_r[i][CROSS_W-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      mx_nxt[j] = ab_r[j][0];
      if (ab_r[j][1] > mx_nxt[j]) mx_nxt[j] = ab_r[j][1];
      if (ab_r[j][2] > mx_nxt[j]) mx_nxt[j] = ab_r[j][2];
    end
    deg_nxt = (mx_nxt[0] == '0) || (mx_nxt[1] == '0);
  end

  always_comb begin
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] lsh;
    logic [POS_W-1:0] rsh;
    for (int j = 0; j < 2; j++) begin
      pos = lead_pos(mx5_r[j]);
      lsh = (pos < POS_W'(NRM_TOP)) ? POS_W'(NRM_TOP) - pos : '0;
      rsh = (pos > POS_W'(NRM_TOP)) ? pos - POS_W'(NRM_TOP) : '0;
      for (int i = 0; i < 3; i++) begin
        nv_nxt[j].m[i] = NRM_W'((ab5_r[j][i] << lsh) >> rsh);
      end
      nv_nxt[j].neg = ng5_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        ab5_r[j] <= ab_r[j];
        ng5_r[j] <= ng_r[j];
        mx5_r[j] <= mx_nxt[j];
        nv6_r[j] <= nv_nxt[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: squares. Stage 8: sum of squares, seeds the first root
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]  sq_r  [2][3];
  nvec_t            nv7_r [2];
  logic [SUM_W-1:0] l1_rem_r  [L1_STEPS][2];
  logic [LEN_W-1:0] l1_root_r [L1_STEPS+1][2];
  nvec_t            l1_nv_r   [L1_STEPS+1][2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 3; i++) begin
          sq_r[j][i] <= SQ_W'(nv6_r[j].m[i]) * SQ_W'(nv6_r[j].m[i]);
        end
        nv7_r[j]        <= nv6_r[j];
        l1_rem_r[0][j]  <= SUM_W'(sq_r[j][0]) + SUM_W'(sq_r[j][1]) + SUM_W'(sq_r[j][2]);
        l1_root_r[0][j] <= '0;
        l1_nv_r[0][j]   <= nv7_r[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Vector length: restoring square root, one result bit per stage
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < L1_STEPS; s++) begin : g_len
    localparam int B = L1_STEPS - 1 - s;
    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [SUM_W:0] trial;
      logic           ge;
      assign trial = ((SUM_W+1)'(l1_root_r[s][j]) << (B + 1)) | ((SUM_W+1)'(1) << (2 * B));
      assign ge    = (SUM_W+1)'(l1_rem_r[s][j]) >= trial;
      always_ff @(posedge clk) begin
        if (adv) begin
          l1_root_r[s+1][j] <= l1_root_r[s][j] | (LEN_W'(ge) << B);
          l1_nv_r[s+1][j]   <= l1_nv_r[s][j];
        end
      end
      if (s < L1_STEPS - 1) begin : g_rem
        logic [SUM_W-1:0] rem_nxt;
        assign rem_nxt = ge ? SUM_W'((SUM_W+1)'(l1_rem_r[s][j]) - trial) : l1_rem_r[s][j];
        always_ff @(posedge clk) begin
          if (adv) l1_rem_r[s+1][j] <= rem_nxt;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Unit vectors: round(m * 2^F / len), one quotient bit per stage
  // --------------------------------------------------------------------------
  logic [DNUM1_W-1:0] d1_rem_r [D1_STEPS][2][3];
  logic [Q1_W-1:0]    d1_q_r   [D1_STEPS+1][2][3];
  logic [LEN_W-1:0]   d1_den_r [D1_STEPS+1][2];
  logic [2:0]         d1_ng_r  [D1_STEPS+1][2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 3; i++) begin
          d1_rem_r[0][j][i] <= (DNUM1_W'(l1_nv_r[L1_STEPS][j].m[i]) << FRAC_BITS)
                             + DNUM1_W'(l1_root_r[L1_STEPS][j] >> 1);
          d1_q_r[0][j][i]   <= '0;
        end
        d1_den_r[0][j] <= l1_root_r[L1_STEPS][j];
        d1_ng_r[0][j]  <= l1_nv_r[L1_STEPS][j].neg;
      end
    end
  end

  for (genvar s = 0; s < D1_STEPS; s++) begin : g_div1
    localparam int B = D1_STEPS - 1 - s;
    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [DNUM1_W:0] trial;
      assign trial = (DNUM1_W+1)'(d1_den_r[s][j]) << B;
      always_ff @(posedge clk) begin
        if (adv) begin
          d1_den_r[s+1][j] <= d1_den_r[s][j];
          d1_ng_r[s+1][j]  <= d1_ng_r[s][j];
        end
      end
      for (genvar i = 0; i < 3; i++) begin : g_comp
        logic ge;
        assign ge = (DNUM1_W+1)'(d1_rem_r[s][j][i]) >= trial;
        always_ff @(posedge clk) begin
          if (adv) d1_q_r[s+1][j][i] <= d1_q_r[s][j][i] | (Q1_W'(ge) << B);
        end
        if (s < D1_STEPS - 1) begin : g_rem
          logic [DNUM1_W-1:0] rem_nxt;
          assign rem_nxt = ge ? DNUM1_W'((DNUM1_W+1)'(d1_rem_r[s][j][i]) - trial)
                              : d1_rem_r[s][j][i];
          always_ff @(posedge clk) begin
            if (adv) d1_rem_r[s+1][j][i] <= rem_nxt;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Signed unit vectors (lane 0 down, lane 1 east), north = east x down,
  // then trace and diagonal compares
  // --------------------------------------------------------------------------
  logic signed [UV_W-1:0] dv_r   [2][3];
  logic signed [UV_W-1:0] dv57_r [2][3];
  logic signed [NP_W-1:0] np_r   [6];
  logic [8:0][M_W-1:0]    mat58_r;
  logic [8:0][M_W-1:0]    mat59_r;
  logic signed [TR_W-1:0] tr59_r;
  logic                   gt01_r;
  logic                   gt02_r;
  logic                   gt12_r;
  logic signed [M_W-1:0]  e58 [9];

  always_comb begin
    for (int k = 0; k < 9; k++) e58[k] = $signed(mat58_r[k]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv_r[j][i] <= d1_ng_r[D1_STEPS][j][i] ? -$signed({1'b0, d1_q_r[D1_STEPS][j][i]})
                                                 :  $signed({1'b0, d1_q_r[D1_STEPS][j][i]});
        end
      end
      dv57_r  <= dv_r;
      np_r[0] <= dv_r[1][1] * dv_r[0][2];
      np_r[1] <= dv_r[1][2] * dv_r[0][1];
      np_r[2] <= dv_r[1][2] * dv_r[0][0];
      np_r[3] <= dv_r[1][0] * dv_r[0][2];
      np_r[4] <= dv_r[1][0] * dv_r[0][1];
      np_r[5] <= dv_r[1][1] * dv_r[0][0];
      // row 0 north, row 1 east, row 2 down
      for (int i = 0; i < 3; i++) begin
        mat58_r[i]   <= round_frac(ND_W'(np_r[2*i]) - ND_W'(np_r[2*i+1]));
        mat58_r[3+i] <= M_W'(dv57_r[1][i]);
        mat58_r[6+i] <= M_W'(dv57_r[0][i]);
      end
      mat59_r <= mat58_r;
      tr59_r  <= TR_W'(e58[0]) + TR_W'(e58[4]) + TR_W'(e58[8]);
      gt01_r  <= e58[0] > e58[4];
      gt02_r  <= e58[0] > e58[8];
      gt12_r  <= e58[4] > e58[8];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 60: pick the branch and its root argument, floor at one
  // --------------------------------------------------------------------------
  logic signed [M_W-1:0]  e59 [9];
  logic signed [TR_W:0]   tt;
  branch_t                br_nxt;
  logic [T_W-1:0]         t_nxt;
  logic [RA_W-1:0]        l2_rem_r  [L2_STEPS];
  logic [R2_W-1:0]        l2_root_r [L2_STEPS+1];
  mat_t                   l2_c_r    [L2_STEPS+1];

  always_comb begin
    for (int k = 0; k < 9; k++) e59[k] = $signed(mat59_r[k]);
    priority if (tr59_r > 0) begin
      br_nxt = BR_W;
      tt     = (TR_W+1)'(ONE) + (TR_W+1)'(tr59_r);
    end else if (gt01_r && gt02_r) begin
      br_nxt = BR_X;
      tt     = (TR_W+1)'(ONE) + (TR_W+1)'(e59[0]) - (TR_W+1)'(e59[4]) - (TR_W+1)'(e59[8]);
    end else if (gt12_r) begin
      br_nxt = BR_Y;
      tt     = (TR_W+1)'(ONE) + (TR_W+1)'(e59[4]) - (TR_W+1)'(e59[0]) - (TR_W+1)'(e59[8]);
    end else begin
      br_nxt = BR_Z;
      tt     = (TR_W+1)'(ONE) + (TR_W+1)'(e59[8]) - (TR_W+1)'(e59[0]) - (TR_W+1)'(e59[4]);
    end
    t_nxt = (tt < 1) ? T_W'(1) : T_W'(tt);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l2_rem_r[0]   <= RA_W'(t_nxt) << FRAC_BITS;
      l2_root_r[0]  <= '0;
      l2_c_r[0].br  <= br_nxt;
      l2_c_r[0].m   <= mat59_r;
    end
  end

  // --------------------------------------------------------------------------
  // Branch root r = floor(sqrt(t * 2^F)), one bit per stage
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < L2_STEPS; s++) begin : g_root
    localparam int B = L2_STEPS - 1 - s;
    logic [RA_W:0] trial;
    logic          ge;
    assign trial = ((RA_W+1)'(l2_root_r[s]) << (B + 1)) | ((RA_W+1)'(1) << (2 * B));
    assign ge    = (RA_W+1)'(l2_rem_r[s]) >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        l2_root_r[s+1] <= l2_root_r[s] | (R2_W'(ge) << B);
        l2_c_r[s+1]    <= l2_c_r[s];
      end
    end
    if (s < L2_STEPS - 1) begin : g_rem
      logic [RA_W-1:0] rem_nxt;
      assign rem_nxt = ge ? RA_W'((RA_W+1)'(l2_rem_r[s]) - trial) : l2_rem_r[s];
      always_ff @(posedge clk) begin
        if (adv) l2_rem_r[s+1] <= rem_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 77: branch numerators, divisor s = 2r, own part round(r / 2)
  // --------------------------------------------------------------------------
  logic signed [M_W-1:0]   e77 [9];
  logic signed [NUM_W-1:0] num [4];
  logic [NUM_W-1:0]        num_mag [4];
  logic [S_W-1:0]          s_nxt;
  logic signed [NUM_W-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  logic [DNUM2_W-1:0]      d2_rem_r [D2_STEPS][4];
  logic [Q2_W-1:0]         d2_q_r   [D2_STEPS+1][4];
  d2c_t                    d2_c_r   [D2_STEPS+1];

  always_comb begin
    for (int k = 0; k < 9; k++) e77[k] = $signed(l2_c_r[L2_STEPS].m[k]);
    d21_12 = NUM_W'(e77[7]) - NUM_W'(e77[5]);
    d02_20 = NUM_W'(e77[2]) - NUM_W'(e77[6]);
    d10_01 = NUM_W'(e77[3]) - NUM_W'(e77[1]);
    s01_10 = NUM_W'(e77[1]) + NUM_W'(e77[3]);
    s02_20 = NUM_W'(e77[2]) + NUM_W'(e77[6]);
    s12_21 = NUM_W'(e77[5]) + NUM_W'(e77[7]);
    // own slot gets a dummy numerator; the final stage substitutes round(r / 2)
    unique case (l2_c_r[L2_STEPS].br)
      BR_W: begin
        num[0] = '0;     num[1] = d21_12; num[2] = d02_20; num[3] = d10_01;
      end
      BR_X: begin
        num[0] = d21_12; num[1] = '0;     num[2] = s01_10; num[3] = s02_20;
      end
      BR_Y: begin
        num[0] = d02_20; num[1] = s01_10; num[2] = '0;     num[3] = s12_21;
      end
      default: begin
        num[0] = d10_01; num[1] = s02_20; num[2] = s12_21; num[3] = '0;
      end
    endcase
    for (int p = 0; p < 4; p++) begin
      num_mag[p] = num[p][NUM_W-1] ? NUM_W'(-num[p]) : NUM_W'(num[p]);
    end
    s_nxt = {l2_root_r[L2_STEPS], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < 4; p++) begin
        d2_rem_r[0][p]  <= (DNUM2_W'(num_mag[p]) << FRAC_BITS) + DNUM2_W'(s_nxt >> 1);
        d2_q_r[0][p]    <= '0;
        d2_c_r[0].neg[p] <= num[p][NUM_W-1];
      end
      d2_c_r[0].br  <= l2_c_r[L2_STEPS].br;
      d2_c_r[0].den <= s_nxt;
      d2_c_r[0].own <= R2_W'((S_W'(l2_root_r[L2_STEPS]) + S_W'(1)) >> 1);
    end
  end

  // --------------------------------------------------------------------------
  // Quaternion parts: round(num * 2^F / s), one quotient bit per stage
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < D2_STEPS; s++) begin : g_div2
    localparam int B = D2_STEPS - 1 - s;
    logic [DV2_W-1:0] trial;
    assign trial = DV2_W'(d2_c_r[s].den) << B;
    always_ff @(posedge clk) begin
      if (adv) d2_c_r[s+1] <= d2_c_r[s];
    end
    for (genvar p = 0; p < 4; p++) begin : g_part
      logic ge;
      assign ge = DV2_W'(d2_rem_r[s][p]) >= trial;
      always_ff @(posedge clk) begin
        if (adv) d2_q_r[s+1][p] <= d2_q_r[s][p] | (Q2_W'(ge) << B);
      end
      if (s < D2_STEPS - 1) begin : g_rem
        logic [DNUM2_W-1:0] rem_nxt;
        assign rem_nxt = ge ? DNUM2_W'(DV2_W'(d2_rem_r[s][p]) - trial) : d2_rem_r[s][p];
        always_ff @(posedge clk) begin
          if (adv) d2_rem_r[s+1][p] <= rem_nxt;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pick own part, clamp to +-1.0, apply sign,
  // replace with identity when degenerate
  // --------------------------------------------------------------------------
  logic signed [OUT_W-1:0] out_q_r [4];
  logic                    out_deg_r;
  logic [OUT_W-1:0]        q_nxt [4];

  always_comb begin
    logic [Q2_W-1:0]  mg;
    logic [OUT_W-1:0] cl;
    logic             own_p;
    for (int p = 0; p < 4; p++) begin
      own_p = (d2_c_r[D2_STEPS].br == branch_t'(2'(p)));
      mg    = own_p ? Q2_W'(d2_c_r[D2_STEPS].own) : d2_q_r[D2_STEPS][p];
      cl    = (mg > Q2_W'(ONE)) ? OUT_W'(ONE) : OUT_W'(mg);
      q_nxt[p] = (d2_c_r[D2_STEPS].neg[p] && !own_p) ? OUT_W'(-cl) : cl;
      if (deg_r[NST-1]) q_nxt[p] = (p == 0) ? OUT_W'(ONE) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < 4; p++) out_q_r[p] <= q_nxt[p];
      out_deg_r <= deg_r[NST-1];
    end
  end

  assign out_tvalid = vld_r[NST];
  assign out_tdata  = {out_q_r[3], out_q_r[2], out_q_r[1], out_q_r[0]};
  assign out_tuser  = out_deg_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `AMQ_ASSERT(a_hold_on_stall, !adv |=> $stable(vld_r), "pipeline moved while stalled")
  `AMQ_ASSERT(a_deg_identity, out_tvalid && out_tuser |-> out_q_r[0] == OUT_W'(ONE) && out_q_r[1] == '0 && out_q_r[2] == '0 && out_q_r[3] == '0, "degenerate result is not identity")
  `AMQ_ASSERT(a_out_range, out_tvalid |-> out_q_r[0] <= ONE && out_q_r[0] >= -ONE && out_q_r[3] <= ONE && out_q_r[3] >= -ONE, "quaternion part out of range")
  `AMQ_ASSERT_RST(a_reset_clears, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule
